// ===== design/rtd_pkg.sv =====
// Shared types and constants for the RTD frame-to-temperature block.
package rtd_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOM = 1'd1;

	localparam logic [31:0] CAL_RESET = 32'd6553600;
	localparam logic [31:0] NOM_RESET = 32'd6553600;

	localparam logic signed [23:0] FULL_SCALE = 24'sd2097152;
	localparam logic signed [28:0] COEF3 = 29'sd920650;
	localparam logic signed [27:0] COEF2 = 28'sd10066330;
	localparam logic signed [33:0] COEF1 = 34'sd268301553;
	localparam logic signed [27:0] X_CLAMP = 28'sd67108864;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

	localparam logic [5:0] MUL_LAST = 6'd22;
	localparam logic [5:0] DIV_LAST = 6'd25;
	localparam logic [5:0] AVG_LAST = 6'd32;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_MUL, S_NUM, S_CLAMP, S_DIV, S_XQ,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
		S_AVG0, S_AVG, S_FIN, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_CHK, OP_MUL, OP_NUM, OP_CLAMP, OP_DIV, OP_XQ,
		OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6,
		OP_AVG0, OP_AVG, OP_FIN, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic rejected;
		logic zero_den;
		logic clamp;
		logic mul_last;
		logic div_last;
		logic avg_last;
	} sts_t;

endpackage

// ===== design/rtd_datapath.sv =====
// Datapath: config registers, shift-add multipliers, divider, polynomial, averager.
module rtd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rtd_pkg::cmd_t                    cmd,
	output rtd_pkg::sts_t                    sts,
	input  logic                             cfg_we,
	input  logic [rtd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [31:0]                      cfg_data,
	input  logic [23:0]                      raw_frame,
	output logic                             accepted,
	output logic                             over_high,
	output logic                             over_low,
	output logic signed [22:0]               signed_code,
	output logic signed [31:0]               temperature
);
	import rtd_pkg::*;

	logic [31:0] cal_q, nom_q;
	logic signed [22:0] wcode_q, code_q;
	logic ok_q, ovh_q, ovl_q;
	logic [54:0] pa_q, pd_q;
	logic s_neg_q, neg_q;
	logic [5:0] cnt_q;
	logic [61:0] r_q;
	logic [25:0] q_q;
	logic signed [27:0] xq_q;
	logic signed [56:0] prod_q;
	logic signed [33:0] b_q;
	logic signed [45:0] lo_q;
	logic signed [31:0] val_q, mean_q;
	logic signed [31:0] rv_q [3];
	logic sneg_q;
	logic [32:0] dq_q;
	logic [1:0] rem_q;
	logic acc_q, ovh_o_q, ovl_o_q;
	logic signed [22:0] sc_q;
	logic signed [31:0] temp_q;

	logic signed [22:0] fcode;
	logic signed [23:0] d_w;
	logic [22:0] code_mag, d_mag;
	logic [32:0] sum_a, sum_d;
	logic signed [56:0] num_w;
	logic [56:0] mag_w;
	logic [61:0] dv_w, r2_w;
	logic r_ge_dv, r2_ge_dv;
	logic signed [28:0] mul_b;
	logic signed [56:0] mul_p;
	logic signed [27:0] a_w;
	logic signed [61:0] full_w;
	logic signed [37:0] p_w;
	logic signed [31:0] sat_w;
	logic signed [33:0] sum3_w;
	logic [2:0] t_w;

	always_comb begin
		if (raw_frame[22])
			fcode = $signed({1'b0, raw_frame[21:0]});
		else if (raw_frame[23])
			fcode = $signed({1'b1, raw_frame[21:0]});
		else
			fcode = $signed({raw_frame[21], raw_frame[21:0]});
	end

	assign d_w      = FULL_SCALE - {wcode_q[22], wcode_q};
	assign code_mag = wcode_q[22] ? (~wcode_q + 23'd1) : wcode_q;
	assign d_mag    = d_w[23] ? 23'(~d_w + 24'd1) : d_w[22:0];
	assign sum_a    = {1'b0, pa_q[54:23]} + (pa_q[0] ? {1'b0, cal_q} : 33'd0);
	assign sum_d    = {1'b0, pd_q[54:23]} + (pd_q[0] ? {1'b0, nom_q} : 33'd0);
	assign num_w    = s_neg_q ? (57'sd0 - $signed({2'b00, pa_q}) - $signed({2'b00, pd_q}))
	                          : ($signed({2'b00, pa_q}) - $signed({2'b00, pd_q}));
	assign mag_w    = num_w[56] ? 57'(-num_w) : num_w;
	assign dv_w     = {1'b0, pd_q, 6'b0};
	assign r_ge_dv  = r_q >= dv_w;
	assign r2_w     = {r_q[60:0], 1'b0};
	assign r2_ge_dv = r2_w >= dv_w;
	assign a_w      = COEF2 + prod_q[47:20];

	always_comb begin
		case (cmd.op)
			OP_P1:   mul_b = COEF3;
			OP_P2:   mul_b = {a_w[27], a_w};
			OP_P4:   mul_b = $signed({12'b0, b_q[16:0]});
			OP_P5:   mul_b = {{12{b_q[33]}}, b_q[33:17]};
			default: mul_b = COEF3;
		endcase
	end

	assign mul_p  = xq_q * mul_b;
	assign full_w = $signed({prod_q[44:0], 17'b0}) + {{16{lo_q[45]}}, lo_q};
	assign p_w    = full_w[61:24];

	always_comb begin
		if (!p_w[37] && (|p_w[36:31]))
			sat_w = VAL_MAX;
		else if (p_w[37] && !(&p_w[36:31]))
			sat_w = VAL_MIN;
		else
			sat_w = p_w[31:0];
	end

	assign sum3_w = {{2{rv_q[2][31]}}, rv_q[2]} + {{2{val_q[31]}}, val_q}
	              + {{2{rv_q[1][31]}}, rv_q[1]};
	assign t_w    = {rem_q, dq_q[32]};

	assign sts.rejected = !ok_q;
	assign sts.zero_den = (d_w == 24'sd0) || (nom_q == 32'd0);
	assign sts.clamp    = r_ge_dv;
	assign sts.mul_last = cnt_q == MUL_LAST;
	assign sts.div_last = cnt_q == DIV_LAST;
	assign sts.avg_last = cnt_q == AVG_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q  <= CAL_RESET;
			nom_q  <= NOM_RESET;
			code_q <= '0;
			mean_q <= '0;
			rv_q   <= '{default: '0};
			cnt_q  <= '0;
		end else begin
			if (cfg_we && cfg_idx == REG_CAL)
				cal_q <= cfg_data;
			if (cfg_we && cfg_idx == REG_NOM)
				nom_q <= cfg_data;
			case (cmd.op)
				OP_CHK, OP_CLAMP: cnt_q <= '0;
				OP_MUL, OP_DIV, OP_AVG: cnt_q <= cnt_q + 6'd1;
				OP_AVG0: begin
					cnt_q   <= '0;
					code_q  <= wcode_q;
					rv_q[0] <= rv_q[1];
					rv_q[1] <= rv_q[2];
					rv_q[2] <= val_q;
				end
				OP_FIN: mean_q <= sneg_q ? $signed(32'(~dq_q + 33'd1)) : $signed(dq_q[31:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				wcode_q <= fcode;
				ok_q    <= !(raw_frame[23] && raw_frame[22]);
				ovh_q   <= raw_frame[22];
				ovl_q   <= raw_frame[23];
			end
			OP_CHK: begin
				pa_q    <= {32'b0, code_mag};
				pd_q    <= {32'b0, d_mag};
				s_neg_q <= wcode_q[22] ^ d_w[23];
				val_q   <= VAL_MAX;
			end
			OP_MUL: begin
				pa_q <= {sum_a, pa_q[22:1]};
				pd_q <= {sum_d, pd_q[22:1]};
			end
			OP_NUM: begin
				neg_q <= num_w[56];
				r_q   <= {5'b0, mag_w};
			end
			OP_CLAMP: begin
				q_q <= '0;
				if (r_ge_dv)
					xq_q <= neg_q ? -X_CLAMP : X_CLAMP;
			end
			OP_DIV: begin
				r_q <= r2_ge_dv ? (r2_w - dv_w) : r2_w;
				q_q <= {q_q[24:0], r2_ge_dv};
			end
			OP_XQ: xq_q <= neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
			OP_P1, OP_P2, OP_P5: prod_q <= mul_p;
			OP_P3: b_q <= COEF1 + prod_q[53:20];
			OP_P4: begin
				prod_q <= mul_p;
				lo_q   <= mul_p[45:0];
			end
			OP_P6: val_q <= sat_w;
			OP_AVG0: begin
				sneg_q <= sum3_w[33];
				dq_q   <= sum3_w[33] ? 33'(-sum3_w) : sum3_w[32:0];
				rem_q  <= '0;
			end
			OP_AVG: begin
				rem_q <= (t_w >= 3'd3) ? 2'(t_w - 3'd3) : t_w[1:0];
				dq_q  <= {dq_q[31:0], t_w >= 3'd3};
			end
			OP_OUT: begin
				acc_q   <= ok_q;
				ovh_o_q <= ovh_q;
				ovl_o_q <= ovl_q;
				sc_q    <= code_q;
				temp_q  <= mean_q;
			end
			default: ;
		endcase
	end

	assign accepted    = acc_q;
	assign over_high   = ovh_o_q;
	assign over_low    = ovl_o_q;
	assign signed_code = sc_q;
	assign temperature = temp_q;

endmodule

// ===== design/rtd_ctrl.sv =====
// Controller state machine sequencing the datapath and both handshakes.
module rtd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rtd_pkg::sts_t sts,
	output rtd_pkg::cmd_t cmd
);
	import rtd_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_CHK;
			S_CHK: begin
				if (sts.rejected)
					state_d = S_DONE;
				else if (sts.zero_den)
					state_d = S_AVG0;
				else
					state_d = S_MUL;
			end
			S_MUL:   if (sts.mul_last) state_d = S_NUM;
			S_NUM:   state_d = S_CLAMP;
			S_CLAMP: state_d = sts.clamp ? S_P1 : S_DIV;
			S_DIV:   if (sts.div_last) state_d = S_XQ;
			S_XQ:    state_d = S_P1;
			S_P1:    state_d = S_P2;
			S_P2:    state_d = S_P3;
			S_P3:    state_d = S_P4;
			S_P4:    state_d = S_P5;
			S_P5:    state_d = S_P6;
			S_P6:    state_d = S_AVG0;
			S_AVG0:  state_d = S_AVG;
			S_AVG:   if (sts.avg_last) state_d = S_FIN;
			S_FIN:   state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_CHK:   cmd.op = OP_CHK;
			S_MUL:   cmd.op = OP_MUL;
			S_NUM:   cmd.op = OP_NUM;
			S_CLAMP: cmd.op = OP_CLAMP;
			S_DIV:   cmd.op = OP_DIV;
			S_XQ:    cmd.op = OP_XQ;
			S_P1:    cmd.op = OP_P1;
			S_P2:    cmd.op = OP_P2;
			S_P3:    cmd.op = OP_P3;
			S_P4:    cmd.op = OP_P4;
			S_P5:    cmd.op = OP_P5;
			S_P6:    cmd.op = OP_P6;
			S_AVG0:  cmd.op = OP_AVG0;
			S_AVG:   cmd.op = OP_AVG;
			S_FIN:   cmd.op = OP_FIN;
			S_DONE:  if (out_free) cmd.op = OP_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_in_to_chk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_CHK)
		else $error("transfer in did not start a frame");
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |=> state_q == S_DIV || state_q == S_XQ)
		else $error("divider left early");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped");
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
		else $error("result not presented");

endmodule

// ===== design/rtd_adc_frame_to_temperature.sv =====
// Top level: RTD converter frame to averaged Q16.16 temperature.
//  channel | signals                                   | transfer
//  in      | in_valid, in_ready, raw_frame             | in_valid & in_ready
//  out     | out_valid, out_ready, accepted, over_high,| out_valid & out_ready
//          | over_low, signed_code, temperature        |
//  cfg     | cfg_we, cfg_idx, cfg_data                 | cfg_we
// A frame runs 23 shift-add multiply steps, 26 divider steps,
// six polynomial steps on one shared multiplier and 33 divide-by-three steps.
// A clamped x skips the divider; a rejected frame goes from the check straight to done.
// One frame is in work at a time; a new frame is taken while the result waits.
// arst_n restores the register defaults and clears code and average history.
module rtd_adc_frame_to_temperature (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [23:0]                   raw_frame,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          accepted,
	output logic                          over_high,
	output logic                          over_low,
	output logic signed [22:0]            signed_code,
	output logic signed [31:0]            temperature,
	input  logic                          cfg_we,
	input  logic [rtd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                   cfg_data
);
	import rtd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.raw_frame   (raw_frame),
		.accepted    (accepted),
		.over_high   (over_high),
		.over_low    (over_low),
		.signed_code (signed_code),
		.temperature (temperature)
	);

endmodule
